// File: hdl/ktt_pkg.sv
// Shared types, codes and constants for the keyed total table with max/min report.
`timescale 1ns / 1ps
`default_nettype none
package ktt_pkg;

    localparam int FUNC_W = 2;
    localparam int KEY_W  = 14;
    localparam int QTY_W  = 16;
    localparam int TOT_W  = 32;
    localparam int SLOT_W = 4;
    localparam int STAT_W = 3;

    localparam logic [KEY_W-1:0] KEY_LOW  = 14'd1000;
    localparam logic [KEY_W-1:0] KEY_HIGH = 14'd9999;
    localparam logic [TOT_W-1:0] TOT_MAX  = {TOT_W{1'b1}};

    // Operation codes carried in the func field.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_ADD    = 2'd1,
        FUNC_REPORT = 2'd2
    } func_t;

    // Status codes returned with every result.
    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_RANGE    = 3'd1,
        ST_DUP      = 3'd2,
        ST_FULL     = 3'd3,
        ST_NOTFOUND = 3'd4,
        ST_EMPTY    = 3'd5
    } status_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [KEY_W-1:0]  key_code;
        logic [QTY_W-1:0]  quantity;
    } in_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] slot;
        logic [KEY_W-1:0]  max_key;
        logic [TOT_W-1:0]  max_total;
        logic [KEY_W-1:0]  min_key;
        logic [TOT_W-1:0]  min_total;
    } out_t;

    // Token that walks the cell row, gathering the outcome of one transaction.
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [KEY_W-1:0]  key_code;
        logic [QTY_W-1:0]  quantity;
        logic              range_ok;
        logic              hit;
        logic              done;
        logic              seen;
        logic [SLOT_W-1:0] slot;
        logic [KEY_W-1:0]  max_key;
        logic [TOT_W-1:0]  max_total;
        logic [KEY_W-1:0]  min_key;
        logic [TOT_W-1:0]  min_total;
    } token_t;

endpackage
`default_nettype wire

// File: hdl/ktt_cell.sv
// One table entry: holds a key and its total and updates the passing token.
`timescale 1ns / 1ps
`default_nettype none
module ktt_cell #(
    parameter int IDX = 0
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            tok_valid_in,
    input  wire ktt_pkg::token_t tok_in,
    output logic                 tok_valid,
    output ktt_pkg::token_t      tok
);

    localparam logic [ktt_pkg::SLOT_W-1:0] MY_SLOT = ktt_pkg::SLOT_W'(IDX);

    logic                        loaded_reg, loaded_next;
    logic [ktt_pkg::KEY_W-1:0]   key_reg, key_next;
    logic [ktt_pkg::TOT_W-1:0]   total_reg, total_next;
    logic                        tok_valid_reg;
    ktt_pkg::token_t             tok_reg, tok_next;
    logic [ktt_pkg::TOT_W:0]     sum;
    logic [ktt_pkg::TOT_W-1:0]   sat_sum;
    logic                        match;

    // Saturating add of the token's quantity onto this entry's total.
    assign sum     = {1'b0, total_reg} + {{(ktt_pkg::TOT_W + 1 - ktt_pkg::QTY_W){1'b0}},
                                           tok_in.quantity};
    assign sat_sum = sum[ktt_pkg::TOT_W] ? ktt_pkg::TOT_MAX : sum[ktt_pkg::TOT_W-1:0];
    assign match   = loaded_reg && (key_reg == tok_in.key_code);

    // Entry update and token update for the transaction passing this cell.
    always_comb
    begin
        loaded_next = loaded_reg;
        key_next    = key_reg;
        total_next  = total_reg;
        tok_next    = tok_in;
        if (tok_valid_in)
        begin
            unique case (tok_in.func)
                ktt_pkg::FUNC_LOAD:
                begin
                    if (match && !tok_in.hit)
                    begin
                        tok_next.hit = 1'b1;
                    end
                    else if (!loaded_reg && !tok_in.hit && !tok_in.done && tok_in.range_ok)
                    begin
                        // Entries fill in order, so the first free one takes the key.
                        loaded_next   = 1'b1;
                        key_next      = tok_in.key_code;
                        total_next    = '0;
                        tok_next.done = 1'b1;
                        tok_next.slot = MY_SLOT;
                    end
                end
                ktt_pkg::FUNC_ADD:
                begin
                    if (match && !tok_in.hit)
                    begin
                        total_next    = sat_sum;
                        tok_next.hit  = 1'b1;
                        tok_next.slot = MY_SLOT;
                    end
                end
                ktt_pkg::FUNC_REPORT:
                begin
                    if (loaded_reg)
                    begin
                        if (!tok_in.seen)
                        begin
                            tok_next.seen      = 1'b1;
                            tok_next.max_key   = key_reg;
                            tok_next.max_total = total_reg;
                            tok_next.min_key   = key_reg;
                            tok_next.min_total = total_reg;
                        end
                        else
                        begin
                            // Strict compares keep the earlier entry on a tie.
                            if (total_reg > tok_in.max_total)
                            begin
                                tok_next.max_key   = key_reg;
                                tok_next.max_total = total_reg;
                            end
                            if (total_reg < tok_in.min_total)
                            begin
                                tok_next.min_key   = key_reg;
                                tok_next.min_total = total_reg;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Control state with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg    <= 1'b0;
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            loaded_reg    <= loaded_next;
            tok_valid_reg <= tok_valid_in;
        end
    end

    // Entry contents and token payload.
    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        total_reg <= total_next;
        tok_reg   <= tok_next;
    end

    assign tok_valid = tok_valid_reg;
    assign tok       = tok_reg;

endmodule
`default_nettype wire

// File: hdl/keyed_total_table_minmax_unit.sv
// Top level: keyed total table built as a row of entry cells with a result stage.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid, in_ready   | in_data  (func, key_code, quantity)
//  out     | out_valid, out_ready | out_data (status, slot, max/min key and total)
//
// A transaction enters as a token that moves one cell per cycle along ENTRIES cells,
// then passes through a hold register and then the output register.
// A new transaction is taken once the previous result reaches the output register,
// so a new token never enters the row while an earlier one is in it or held.
// Reset clears every entry's loaded flag, which empties the table at once.
// A stalled output keeps the next transaction's result waiting in the hold register.
`timescale 1ns / 1ps
`default_nettype none
module keyed_total_table_minmax_unit #(
    parameter int ENTRIES = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire ktt_pkg::in_t in_data,
    output logic              out_valid,
    input  wire logic         out_ready,
    output ktt_pkg::out_t     out_data
);

    ktt_pkg::token_t   tok_chain [ENTRIES+1];
    ktt_pkg::token_t   tok_first;
    logic [ENTRIES:0]  tok_vld;
    logic              busy_reg, busy_next;
    logic              hold_valid_reg, hold_valid_next;
    ktt_pkg::out_t     hold_reg, hold_next;
    logic              out_valid_reg, out_valid_next;
    ktt_pkg::out_t     out_reg, out_next;
    ktt_pkg::out_t     result;
    ktt_pkg::token_t   tok_end;
    logic              accept;

    assign in_ready = !busy_reg;
    assign accept   = in_valid && in_ready;

    // Fresh token entering the first cell.
    always_comb
    begin
        tok_first           = '0;
        tok_first.func      = in_data.func;
        tok_first.key_code  = in_data.key_code;
        tok_first.quantity  = in_data.quantity;
        tok_first.range_ok  = (in_data.key_code >= ktt_pkg::KEY_LOW) &&
                              (in_data.key_code <= ktt_pkg::KEY_HIGH);
    end
    assign tok_chain[0] = tok_first;
    assign tok_vld[0]   = accept;

    // Row of entry cells.
    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        ktt_cell #(
            .IDX(i)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .tok_valid_in (tok_vld[i]),
            .tok_in       (tok_chain[i]),
            .tok_valid    (tok_vld[i+1]),
            .tok          (tok_chain[i+1])
        );
    end

    assign tok_end = tok_chain[ENTRIES];

    // Turn the finished token into a result.
    always_comb
    begin
        result        = '0;
        result.status = ktt_pkg::ST_OK;
        unique case (tok_end.func)
            ktt_pkg::FUNC_LOAD:
            begin
                if (!tok_end.range_ok)
                begin
                    result.status = ktt_pkg::ST_RANGE;
                end
                else if (tok_end.hit)
                begin
                    result.status = ktt_pkg::ST_DUP;
                end
                else if (!tok_end.done)
                begin
                    result.status = ktt_pkg::ST_FULL;
                end
                else
                begin
                    result.slot = tok_end.slot;
                end
            end
            ktt_pkg::FUNC_ADD:
            begin
                if (tok_end.hit)
                begin
                    result.slot = tok_end.slot;
                end
                else
                begin
                    result.status = ktt_pkg::ST_NOTFOUND;
                end
            end
            ktt_pkg::FUNC_REPORT:
            begin
                if (tok_end.seen)
                begin
                    result.max_key   = tok_end.max_key;
                    result.max_total = tok_end.max_total;
                    result.min_key   = tok_end.min_key;
                    result.min_total = tok_end.min_total;
                end
                else
                begin
                    result.status = ktt_pkg::ST_EMPTY;
                end
            end
            default:
            begin
                result.status = ktt_pkg::ST_RANGE;
            end
        endcase
    end

    // Hold and output stages.
    always_comb
    begin
        busy_next       = busy_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (tok_vld[ENTRIES])
        begin
            hold_valid_next = 1'b1;
            hold_next       = result;
        end
        else if (hold_valid_reg && (!out_valid_reg || out_ready))
        begin
            hold_valid_next = 1'b0;
            out_valid_next  = 1'b1;
            out_next        = hold_reg;
            busy_next       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        out_reg  <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTH
    // Only one transaction is ever in flight along the cell row.
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_vld))
        else $error("more than one token in the cell row");

    // A token in the row or a held result implies the unit is busy.
    a_busy_cover: assert property (@(posedge clk) disable iff (!rst_n)
        ((|tok_vld[ENTRIES:1]) || hold_valid_reg) |-> busy_reg)
        else $error("work in flight while the unit reports idle");

    // An accepted transaction keeps the unit busy in the following cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg)
        else $error("unit not busy after accepting a transaction");

    // A token never reaches the end while a result is still held.
    a_hold_free: assert property (@(posedge clk) disable iff (!rst_n)
        tok_vld[ENTRIES] |-> !hold_valid_reg)
        else $error("result arrived while hold register was full");
`endif

endmodule
`default_nettype wire

// File: tb/keyed_total_table_minmax_unit_tb.sv
// Testbench for the keyed total table: directed and random transactions against a predictor.
`timescale 1ns / 1ps
module keyed_total_table_minmax_unit_tb;

    localparam int ENTRIES      = 16;
    localparam int RANDOM_ITEMS = 540;
    localparam int POOL_SIZE    = 24;
    localparam int DRAIN_CYCLES = 40;
    localparam int HEAVY_ADDS   = 16;

    localparam logic [ktt_pkg::FUNC_W-1:0] FUNC_UNDEF   = 2'd3;
    localparam logic [ktt_pkg::KEY_W-1:0]  KEY_ALL_ONES = {ktt_pkg::KEY_W{1'b1}};
    localparam logic [ktt_pkg::QTY_W-1:0]  QTY_MAX      = {ktt_pkg::QTY_W{1'b1}};

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_ready;
    ktt_pkg::in_t  in_data;
    logic          out_valid;
    logic          out_ready;
    ktt_pkg::out_t out_data;

    // Predicted contents of the key table.
    logic [ktt_pkg::KEY_W-1:0] tbl_keys [ENTRIES];
    logic [ktt_pkg::TOT_W-1:0] tbl_totals [ENTRIES];
    int                        tbl_count;

    // Results still owed by the block, oldest first.
    ktt_pkg::out_t             expected_results [$];
    int                        mismatches;
    bit                        no_idle;
    logic [ktt_pkg::KEY_W-1:0] key_pool [POOL_SIZE];

    keyed_total_table_minmax_unit #(
        .ENTRIES(ENTRIES)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Number of idle cycles before the next transaction on either side.
    function automatic int pick_gap();
        return no_idle ? 0 : $urandom_range(0, 6);
    endfunction

    // Slot holding the key among the loaded entries, or -1 if it is absent.
    function automatic int find_slot(logic [ktt_pkg::KEY_W-1:0] key);
        for (int i = 0; i < tbl_count; i++)
        begin
            if (tbl_keys[i] == key)
                return i;
        end
        return -1;
    endfunction

    // Applies one transaction to the predicted table and returns its result.
    function automatic ktt_pkg::out_t predict_result(ktt_pkg::in_t item);
        ktt_pkg::out_t           res;
        int                      idx;
        logic [ktt_pkg::TOT_W:0] sum;
        res = '0;
        idx = find_slot(item.key_code);
        if (item.func == ktt_pkg::FUNC_LOAD)
        begin
            if (item.key_code < ktt_pkg::KEY_LOW || item.key_code > ktt_pkg::KEY_HIGH)
                res.status = ktt_pkg::ST_RANGE;
            else if (idx >= 0)
                res.status = ktt_pkg::ST_DUP;
            else if (tbl_count >= ENTRIES)
                res.status = ktt_pkg::ST_FULL;
            else
            begin
                tbl_keys[tbl_count]   = item.key_code;
                tbl_totals[tbl_count] = '0;
                res.status = ktt_pkg::ST_OK;
                res.slot   = ktt_pkg::SLOT_W'(tbl_count);
                tbl_count++;
            end
        end
        else if (item.func == ktt_pkg::FUNC_ADD)
        begin
            if (idx < 0)
                res.status = ktt_pkg::ST_NOTFOUND;
            else
            begin
                // Totals clamp at the top instead of wrapping.
                sum = {1'b0, tbl_totals[idx]} +
                      {{(ktt_pkg::TOT_W + 1 - ktt_pkg::QTY_W){1'b0}}, item.quantity};
                tbl_totals[idx] = sum[ktt_pkg::TOT_W] ? ktt_pkg::TOT_MAX
                                                      : sum[ktt_pkg::TOT_W-1:0];
                res.status = ktt_pkg::ST_OK;
                res.slot   = ktt_pkg::SLOT_W'(idx);
            end
        end
        else if (item.func == ktt_pkg::FUNC_REPORT)
        begin
            if (tbl_count == 0)
                res.status = ktt_pkg::ST_EMPTY;
            else
            begin
                // Strict comparisons keep the earliest slot on ties.
                res.status    = ktt_pkg::ST_OK;
                res.max_key   = tbl_keys[0];
                res.max_total = tbl_totals[0];
                res.min_key   = tbl_keys[0];
                res.min_total = tbl_totals[0];
                for (int i = 1; i < tbl_count; i++)
                begin
                    if (tbl_totals[i] > res.max_total)
                    begin
                        res.max_total = tbl_totals[i];
                        res.max_key   = tbl_keys[i];
                    end
                    if (tbl_totals[i] < res.min_total)
                    begin
                        res.min_total = tbl_totals[i];
                        res.min_key   = tbl_keys[i];
                    end
                end
            end
        end
        else
            res.status = ktt_pkg::ST_RANGE;
        return res;
    endfunction

    // Drives one transaction and records its expected result once accepted.
    // Valid stays high after acceptance so that back-to-back sends never
    // lower and raise it in the same step.
    task automatic send_item(input logic [ktt_pkg::FUNC_W-1:0] f,
                             input logic [ktt_pkg::KEY_W-1:0] k,
                             input logic [ktt_pkg::QTY_W-1:0] q);
        int           gap;
        ktt_pkg::in_t item;
        item = '{func: f, key_code: k, quantity: q};
        gap  = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (!in_ready);
        expected_results.push_back(predict_result(item));
        @(negedge clk);
    endtask

    // Holds off the sender until every outstanding result has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_empty_table();
        send_item(ktt_pkg::FUNC_REPORT, 14'd0, 16'd0);
        send_item(ktt_pkg::FUNC_ADD, 14'd1234, 16'd5);
        send_item(FUNC_UNDEF, 14'd0, 16'd0);
    endtask

    task automatic test_load_checks();
        send_item(ktt_pkg::FUNC_LOAD, 14'd999, 16'd0);
        send_item(ktt_pkg::FUNC_LOAD, 14'd10000, 16'd0);
        send_item(ktt_pkg::FUNC_LOAD, 14'd0, 16'd0);
        send_item(ktt_pkg::FUNC_LOAD, KEY_ALL_ONES, 16'd0);
        send_item(ktt_pkg::FUNC_LOAD, ktt_pkg::KEY_LOW, 16'd0);
        send_item(ktt_pkg::FUNC_LOAD, ktt_pkg::KEY_HIGH, 16'd0);
        send_item(ktt_pkg::FUNC_LOAD, ktt_pkg::KEY_LOW, 16'd0);
    endtask

    task automatic test_add_and_ties();
        // Both totals are zero here, so the first slot wins both ways.
        send_item(ktt_pkg::FUNC_REPORT, 14'd0, 16'd0);
        send_item(ktt_pkg::FUNC_ADD, ktt_pkg::KEY_HIGH, QTY_MAX);
        send_item(ktt_pkg::FUNC_ADD, ktt_pkg::KEY_LOW, QTY_MAX);
        wait_drained();
        send_item(ktt_pkg::FUNC_REPORT, 14'd0, 16'd0);
        send_item(ktt_pkg::FUNC_ADD, ktt_pkg::KEY_LOW, 16'd0);
        send_item(ktt_pkg::FUNC_ADD, 14'd0, 16'd7);
        send_item(ktt_pkg::FUNC_ADD, KEY_ALL_ONES, 16'd0);
        send_item(FUNC_UNDEF, KEY_ALL_ONES, QTY_MAX);
    endtask

    // Key for a random transaction: mostly loaded or pooled keys, some noise.
    function automatic logic [ktt_pkg::KEY_W-1:0] pick_key(bit for_load);
        int r;
        r = $urandom_range(0, 99);
        if (!for_load && tbl_count > 0 && r < 70)
            return tbl_keys[$urandom_range(0, tbl_count - 1)];
        if (r < 85)
            return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (r < 92)
            return ktt_pkg::KEY_W'($urandom_range(1000, 9999));
        return ktt_pkg::KEY_W'($urandom_range(0, 16383));
    endfunction

    task automatic test_random_traffic();
        int                            r;
        logic [ktt_pkg::FUNC_W-1:0]    f;
        logic [ktt_pkg::KEY_W-1:0]     k;
        logic [ktt_pkg::QTY_W-1:0]     q;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // Periodic stretches with no idle cycles on either side.
            no_idle = (n % 150) >= 120;
            if ($urandom_range(0, 39) == 0)
                wait_drained();
            r = $urandom_range(0, 9);
            if (r < 5)
                q = ktt_pkg::QTY_W'($urandom_range(0, 15));
            else if (r < 8)
                q = ktt_pkg::QTY_W'($urandom);
            else if (r == 8)
                q = '0;
            else
                q = QTY_MAX;
            r = $urandom_range(0, 99);
            if (r < 15)
            begin
                f = ktt_pkg::FUNC_LOAD;
                k = pick_key(1'b1);
            end
            else if (r < 65)
            begin
                f = ktt_pkg::FUNC_ADD;
                k = pick_key(1'b0);
            end
            else if (r < 88)
            begin
                f = ktt_pkg::FUNC_REPORT;
                k = pick_key(1'b0);
            end
            else if (r < 94)
            begin
                f = FUNC_UNDEF;
                k = pick_key(1'b0);
            end
            else
            begin
                f = ktt_pkg::FUNC_W'($urandom_range(0, 3));
                k = ktt_pkg::KEY_W'($urandom_range(0, 16383));
            end
            send_item(f, k, q);
        end
        no_idle = 1'b0;
    endtask

    task automatic test_full_table();
        logic [ktt_pkg::KEY_W-1:0] k;
        while (tbl_count < ENTRIES)
        begin
            do
                k = ktt_pkg::KEY_W'($urandom_range(1000, 9999));
            while (find_slot(k) >= 0);
            send_item(ktt_pkg::FUNC_LOAD, k, 16'd0);
        end
        // A fresh key is refused, while range and duplicate checks still come first.
        do
            k = ktt_pkg::KEY_W'($urandom_range(1000, 9999));
        while (find_slot(k) >= 0);
        send_item(ktt_pkg::FUNC_LOAD, k, 16'd0);
        send_item(ktt_pkg::FUNC_LOAD, tbl_keys[ENTRIES - 1], 16'd0);
        send_item(ktt_pkg::FUNC_LOAD, 14'd500, 16'd0);
        send_item(ktt_pkg::FUNC_ADD, tbl_keys[ENTRIES - 1], 16'd3);
        send_item(ktt_pkg::FUNC_REPORT, 14'd0, 16'd0);
    endtask

    // Back-to-back full-scale adds onto one key, then a zero add and a report.
    task automatic test_large_totals();
        logic [ktt_pkg::KEY_W-1:0] k;
        no_idle = 1'b1;
        k = tbl_keys[0];
        repeat (HEAVY_ADDS)
            send_item(ktt_pkg::FUNC_ADD, k, QTY_MAX);
        send_item(ktt_pkg::FUNC_ADD, k, 16'd0);
        no_idle = 1'b0;
        send_item(ktt_pkg::FUNC_REPORT, 14'd0, 16'd0);
    endtask

    // Result side: random stalls between transactions.
    initial
    begin
        int stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = pick_gap();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            @(negedge clk);
        end
    end

    task automatic compare_field(input string label, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, label, want, got);
        end
    endtask

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        ktt_pkg::out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual %h",
                         $time, out_data);
            end
            else
            begin
                want = expected_results.pop_front();
                compare_field("status", 32'(want.status), 32'(out_data.status));
                compare_field("slot", 32'(want.slot), 32'(out_data.slot));
                compare_field("max_key", 32'(want.max_key), 32'(out_data.max_key));
                compare_field("max_total", want.max_total, out_data.max_total);
                compare_field("min_key", 32'(want.min_key), 32'(out_data.min_key));
                compare_field("min_total", want.min_total, out_data.min_total);
            end
        end
    end

    // Main sequence.
    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        no_idle    = 1'b0;
        mismatches = 0;
        tbl_count  = 0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            tbl_keys[i]   = '0;
            tbl_totals[i] = '0;
        end
        // Pooled keys are spread over the valid range and distinct by construction.
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = ktt_pkg::KEY_W'(1000 + i * 375 + $urandom_range(0, 374));
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_empty_table();
        test_load_checks();
        test_add_and_ties();
        test_random_traffic();
        test_full_table();
        test_large_totals();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("keyed_total_table_minmax_unit_tb OK");
        else
            $display("keyed_total_table_minmax_unit_tb NOT OK");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #(5_000_000);
        $display("keyed_total_table_minmax_unit_tb NOT OK");
        $finish;
    end

endmodule
